// File: hw/rtl/kmp_pkg.sv
`timescale 1ns / 1ps

package kmp_pkg;

	localparam int MAX_PATTERN_DEF = 256;
	localparam int COUNT_BITS_DEF  = 32;
	localparam int REPORT_BITS     = 32;

	typedef enum logic [1:0] {
		REQ_CLEAR  = 2'd0,
		REQ_APPEND = 2'd1,
		REQ_START  = 2'd2,
		REQ_TEXT   = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	// controller -> datapath
	typedef struct packed {
		logic accept;  // latch the request beat
		logic follow;  // load the walk pointer from the failure table read
		logic commit;  // update state and load the output register
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic need_fetch; // text byte with the state at a full match
		logic need_walk;  // request walks the failure chain
		logic walk_done;  // chain walk reached a hit or the root
		logic out_free;   // output register can take a beat
	} stat_t;

endpackage

// File: hw/rtl/kmp_stream_matcher.sv
`timescale 1ns / 1ps

// Channel   Dir  Signals                    Beat contents
// s_*       in   tvalid tready tdata tuser  tdata: data_byte; tuser: req_type
// m_*       out  tvalid tready tdata tuser  tdata: match_count; tuser: match_found, status
//
// Clear, start, a dropped pattern byte and a text byte with an empty pattern
// go from idle straight to the response state. Any other append or text byte
// also walks the failure table, one step per cycle, as the table read port is
// registered; a text byte whose state sits at a full match adds a fetch state.
// KMP bounds the walk to two steps per byte on average.
// Reset (arst_n) clears length, prefix, match state and count; the pattern and
// failure stores are not cleared and need no pass after reset.
// A result that waits in the output register holds the commit of the next item.

module kmp_stream_matcher
	import kmp_pkg::*;
#(
	parameter int MAX_PATTERN = MAX_PATTERN_DEF,
	parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [7:0]             s_tdata,  // [7:0] data_byte
	input  logic [1:0]             s_tuser,  // [1:0] req_type
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [REPORT_BITS-1:0] m_tdata,  // [31:0] match_count
	output logic [2:0]             m_tuser   // [0] match_found, [2:1] status
);

	cmd_t    cmd;
	stat_t   stat;
	logic    out_found;
	status_t out_status;

	// Sequencer: accept a beat, walk the failure chain, commit the result.
	kmp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Pattern and failure stores, walk pointer, state and the output register.
	kmp_dp #(
		.MAX_PATTERN (MAX_PATTERN),
		.COUNT_BITS  (COUNT_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.req_in     (req_t'(s_tuser)),
		.byte_in    (s_tdata),
		.out_ready  (m_tready),
		.out_valid  (m_tvalid),
		.out_found  (out_found),
		.out_count  (m_tdata),
		.out_status (out_status)
	);

	assign m_tuser = {out_status, out_found};

	// One beat in flight: the input side closes right after a beat is taken.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input accepted while an item is in flight");

	// A reported match always carries an ok status.
	a_match_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[0]) |-> (m_tuser[2:1] == ST_OK))
		else $error("match reported with a non-ok status");

	// A commit always presents a result beat in the next cycle.
	a_commit_out: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> m_tvalid)
		else $error("commit without an output beat");

	// The chain walk never runs while the input side is open.
	a_walk_closed: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.follow |-> !s_tready)
		else $error("failure walk while idle");

endmodule

// File: hw/rtl/kmp_ctrl.sv
`timescale 1ns / 1ps

module kmp_ctrl
	import kmp_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  s_tvalid,
	output logic  s_tready,
	input  stat_t stat,
	output cmd_t  cmd
);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_FETCH = 4'b0010,
		S_WALK  = 4'b0100,
		S_RESP  = 4'b1000
	} state_t;

	state_t state_q, state_d;

	assign s_tready = (state_q == S_IDLE);

	always_comb begin
		state_d    = state_q;
		cmd.accept = 1'b0;
		cmd.follow = 1'b0;
		cmd.commit = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.accept = 1'b1;
					if (stat.need_fetch) begin
						state_d = S_FETCH;
					end else if (stat.need_walk) begin
						state_d = S_WALK;
					end else begin
						state_d = S_RESP;
					end
				end
			end
			S_FETCH: begin
				cmd.follow = 1'b1;
				state_d    = S_WALK;
			end
			S_WALK: begin
				if (stat.walk_done) begin
					state_d = S_RESP;
				end else begin
					cmd.follow = 1'b1;
				end
			end
			S_RESP: begin
				if (stat.out_free) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// File: hw/rtl/kmp_dp.sv
`timescale 1ns / 1ps

module kmp_dp
	import kmp_pkg::*;
#(
	parameter int MAX_PATTERN = MAX_PATTERN_DEF,
	parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cmd_t                   cmd,
	output stat_t                  stat,
	input  req_t                   req_in,
	input  logic [7:0]             byte_in,
	input  logic                   out_ready,
	output logic                   out_valid,
	output logic                   out_found,
	output logic [REPORT_BITS-1:0] out_count,
	output status_t                out_status
);

	// Positions are kept as (KMP index + 1) so that -1 becomes zero.
	localparam int LW = $clog2(MAX_PATTERN + 1);
	localparam int PA = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
	localparam logic [LW-1:0] LEN_MAX = LW'(MAX_PATTERN);

	logic [7:0]    pat_mem [0:MAX_PATTERN-1];
	logic [LW-1:0] fail_mem [0:MAX_PATTERN];

	logic [LW-1:0]         len_q, bld_q, mst_q, q_q;
	logic [LW-1:0]         len_d, bld_d, mst_d, q_d;
	logic [COUNT_BITS-1:0] cnt_q, cnt_d;
	req_t                  req_q;
	logic [7:0]            byte_q;
	status_t               st_q, st_in;
	logic [7:0]            p_rd_q;
	logic [LW-1:0]         f_rd_q, f_eff;
	logic                  f_zero_q;
	logic [LW-1:0]         f_idx;
	logic [PA-1:0]         p_idx;
	logic                  found_d;
	logic                  out_valid_q, out_found_q;
	logic [REPORT_BITS-1:0] out_count_q;
	status_t               out_status_q;

	always_comb begin
		st_in = ST_OK;
		if (req_in == REQ_APPEND && len_q == LEN_MAX) begin
			st_in = ST_FULL;
		end else if (req_in == REQ_TEXT && len_q == '0) begin
			st_in = ST_EMPTY;
		end
	end

	assign stat.need_fetch = (req_in == REQ_TEXT) && (len_q != '0) && (mst_q == len_q);
	assign stat.need_walk  = ((req_in == REQ_APPEND) && (len_q != LEN_MAX)) ||
		((req_in == REQ_TEXT) && (len_q != '0) && (mst_q != len_q));
	assign stat.walk_done  = (q_q == '0) || (p_rd_q == byte_q);
	assign stat.out_free   = !out_valid_q || out_ready;

	// Failure entry zero is the root and always reads as zero.
	assign f_eff = f_zero_q ? '0 : f_rd_q;

	always_comb begin
		q_d = q_q;
		if (cmd.accept) begin
			if (req_in == REQ_APPEND) begin
				q_d = bld_q;
			end else begin
				q_d = LW'(mst_q + 1'b1);
			end
		end else if (cmd.follow) begin
			q_d = f_eff;
		end
	end

	// Read ahead so the data for the next pointer is ready next cycle.
	assign p_idx = PA'(q_d - LW'(1));
	assign f_idx = (cmd.accept && stat.need_fetch) ? len_q : LW'(q_d - LW'(1));

	always_ff @(posedge clk) begin
		p_rd_q   <= pat_mem[p_idx];
		f_rd_q   <= fail_mem[f_idx];
		f_zero_q <= (f_idx == '0);
		if (cmd.accept && req_in == REQ_APPEND && st_in == ST_OK) begin
			pat_mem[PA'(len_q)] <= byte_in;
		end
		if (cmd.commit && req_q == REQ_APPEND && st_q == ST_OK) begin
			fail_mem[LW'(len_q + 1'b1)] <= LW'(q_q + 1'b1);
		end
	end

	always_comb begin
		len_d   = len_q;
		bld_d   = bld_q;
		mst_d   = mst_q;
		cnt_d   = cnt_q;
		found_d = 1'b0;
		unique case (req_q)
			REQ_CLEAR: begin
				len_d = '0;
				bld_d = '0;
				mst_d = '0;
			end
			REQ_APPEND: begin
				if (st_q == ST_OK) begin
					bld_d = LW'(q_q + 1'b1);
					len_d = LW'(len_q + 1'b1);
				end
			end
			REQ_START: begin
				mst_d = '0;
				cnt_d = '0;
			end
			REQ_TEXT: begin
				if (st_q == ST_OK) begin
					mst_d   = q_q;
					found_d = (q_q == len_q);
					if (found_d && cnt_q != '1) begin
						cnt_d = cnt_q + 1'b1;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			req_q  <= req_in;
			byte_q <= byte_in;
			st_q   <= st_in;
		end
		if (cmd.accept || cmd.follow) begin
			q_q <= q_d;
		end
		if (cmd.commit) begin
			out_found_q  <= found_d;
			out_count_q  <= REPORT_BITS'(cnt_d);
			out_status_q <= st_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q       <= '0;
			bld_q       <= '0;
			mst_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.commit) begin
				len_q       <= len_d;
				bld_q       <= bld_d;
				mst_q       <= mst_d;
				cnt_q       <= cnt_d;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign out_found  = out_found_q;
	assign out_count  = out_count_q;
	assign out_status = out_status_q;

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import kmp_pkg::*;

	localparam int HANG_LIMIT = 4000;
	localparam int RANDOM_TARGET = 520;
	localparam int TAIL_BEATS = 60;

	typedef struct {
		req_t       kind;
		logic [7:0] data;
	} request_t;

	typedef struct {
		logic             found;
		logic [31:0]      count;
		status_t          status;
	} report_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [7:0]             s_tdata = 8'h00;
	logic [1:0]             s_tuser = REQ_CLEAR;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [REPORT_BITS-1:0] m_tdata;
	logic [2:0]             m_tuser;

	request_t pending_requests[$];
	report_t  predicted_reports[$];

	// Predictor state
	logic [7:0]  pat_mem [MAX_PATTERN_DEF];
	int          fail_mem [MAX_PATTERN_DEF + 1];
	int          pat_len;
	int          grow_pos;
	int          scan_pos;
	logic [31:0] hit_total;

	int n_items = 0;
	int n_reports = 0;
	int n_errors = 0;
	int idle_left = 0;
	int stall_left = 0;
	int hang_cycles = 0;

	kmp_stream_matcher uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Walk the failure chain until byte c extends position p
	function automatic int retreat(int p, logic [7:0] c);
		while (p >= 0 && p < pat_len && pat_mem[p] != c)
			p = fail_mem[p];
		return p;
	endfunction

	function automatic report_t kmp_predict(req_t kind, logic [7:0] c);
		report_t r;
		int j;
		r.found = 1'b0;
		r.status = ST_OK;
		case (kind)
			REQ_CLEAR: begin
				pat_len = 0;
				grow_pos = -1;
				scan_pos = 0;
				fail_mem[0] = -1;
			end
			REQ_APPEND: begin
				if (pat_len >= MAX_PATTERN_DEF) begin
					r.status = ST_FULL;
				end else begin
					pat_mem[pat_len] = c;
					pat_len = pat_len + 1;
					grow_pos = retreat(grow_pos, c) + 1;
					fail_mem[pat_len] = grow_pos;
				end
			end
			REQ_START: begin
				scan_pos = 0;
				hit_total = '0;
			end
			default: begin
				if (pat_len == 0) begin
					r.status = ST_EMPTY;
				end else begin
					j = scan_pos;
					// state at a full match falls back before the compare
					if (j >= pat_len)
						j = fail_mem[pat_len];
					j = retreat(j, c) + 1;
					scan_pos = j;
					if (j == pat_len) begin
						r.found = 1'b1;
						if (hit_total != '1)
							hit_total = hit_total + 1;
					end
				end
			end
		endcase
		r.count = hit_total;
		return r;
	endfunction

	task automatic push(req_t kind, logic [7:0] data);
		request_t rq;
		rq.kind = kind;
		rq.data = data;
		pending_requests.push_back(rq);
		n_items++;
	endtask

	// Driver: present queued requests, with idle bursts outside the tail
	always @(posedge clk or negedge arst_n) begin
		request_t rq;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= 8'h00;
			s_tuser <= REQ_CLEAR;
			idle_left <= 0;
		end else begin
			if (s_tvalid && s_tready)
				predicted_reports.push_back(kmp_predict(req_t'(s_tuser), s_tdata));
			if (!s_tvalid || s_tready) begin
				if (idle_left > 0) begin
					s_tvalid <= 1'b0;
					idle_left <= idle_left - 1;
				end else if (pending_requests.size() > TAIL_BEATS
						&& ((pending_requests.size() / 64) % 2 == 0)
						&& $urandom_range(0, 7) == 0) begin
					s_tvalid <= 1'b0;
					idle_left <= $urandom_range(1, 15) - 1;
				end else if (pending_requests.size() > 0) begin
					rq = pending_requests.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= rq.data;
					s_tuser <= rq.kind;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Monitor: check each report beat against the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		report_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall_left <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				n_reports++;
				if (predicted_reports.size() == 0) begin
					n_errors++;
					if (n_errors <= 10)
						$display("unexpected report: found %0b count %0d status %0d",
							m_tuser[0], m_tdata, m_tuser[2:1]);
				end else begin
					want = predicted_reports.pop_front();
					if (m_tuser[0] !== want.found || m_tdata !== want.count
							|| m_tuser[2:1] !== want.status) begin
						n_errors++;
						if (n_errors <= 10)
							$display({"report %0d mismatch: expected found %0b count %0d",
								" status %0d, got found %0b count %0d status %0d"},
								n_reports, want.found, want.count, want.status,
								m_tuser[0], m_tdata, m_tuser[2:1]);
					end
				end
			end
			if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left <= stall_left - 1;
			end else if (pending_requests.size() > TAIL_BEATS
					&& ((n_reports / 64) % 2 == 1)
					&& $urandom_range(0, 9) == 0) begin
				m_tready <= 1'b0;
				stall_left <= $urandom_range(1, 15) - 1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Watchdog: count cycles with no beat on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				hang_cycles <= 0;
			else
				hang_cycles <= hang_cycles + 1;
			if (hang_cycles >= HANG_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	initial begin
		logic [7:0] sym [3];
		logic [7:0] word [$];
		int plen;
		int tlen;
		int pick;
		bit full_done;
		full_done = 0;

		for (int i = 0; i < MAX_PATTERN_DEF; i++)
			pat_mem[i] = 8'h00;
		for (int i = 0; i <= MAX_PATTERN_DEF; i++)
			fail_mem[i] = 0;
		fail_mem[0] = -1;
		pat_len = 0;
		grow_pos = -1;
		scan_pos = 0;
		hit_total = '0;

		// Directed: empty pattern, extreme bytes, overlaps, growth mid-text
		push(REQ_CLEAR, 8'hA5);
		push(REQ_TEXT, 8'h00);
		push(REQ_START, 8'h5A);
		push(REQ_TEXT, 8'hFF);
		push(REQ_APPEND, 8'h00);
		push(REQ_APPEND, 8'hFF);
		push(REQ_APPEND, 8'h00);
		push(REQ_START, 8'hFF);
		for (int i = 0; i < 7; i++)
			push(REQ_TEXT, (i % 2 == 0) ? 8'h00 : 8'hFF);
		push(REQ_TEXT, 8'h00);
		push(REQ_APPEND, 8'hFF);
		push(REQ_TEXT, 8'hFF);
		push(REQ_TEXT, 8'h00);
		push(REQ_TEXT, 8'hFF);
		push(REQ_CLEAR, 8'h00);
		push(REQ_TEXT, 8'h80);
		push(REQ_START, 8'h00);

		// Random: mostly well-formed pattern/text sessions over a small alphabet
		while (n_items < RANDOM_TARGET) begin
			for (int i = 0; i < 3; i++)
				sym[i] = 8'($urandom_range(0, 255));
			if (!full_done && n_items > 150) begin
				// fill the pattern past its capacity, then scan against it
				full_done = 1;
				push(REQ_CLEAR, 8'($urandom));
				for (int i = 0; i < MAX_PATTERN_DEF + 2; i++)
					push(REQ_APPEND, (i % 7 == 6) ? sym[1] : sym[0]);
				push(REQ_START, 8'($urandom));
				for (int i = 0; i < 30; i++)
					push(REQ_TEXT, ($urandom_range(0, 5) == 0) ? sym[1] : sym[0]);
				push(REQ_CLEAR, 8'($urandom));
				continue;
			end
			pick = $urandom_range(0, 9);
			if (pick <= 7) begin
				word.delete();
				plen = $urandom_range(1, 6);
				for (int i = 0; i < plen; i++)
					word.push_back(sym[$urandom_range(0, 1 + (pick % 2))]);
				if ($urandom_range(0, 4) != 0)
					push(REQ_CLEAR, 8'($urandom));
				foreach (word[i])
					push(REQ_APPEND, word[i]);
				push(REQ_START, 8'($urandom));
				tlen = $urandom_range(8, 30);
				for (int i = 0; i < tlen; i++) begin
					if (pick >= 6)
						push(REQ_TEXT, word[i % plen]);
					else
						push(REQ_TEXT, sym[$urandom_range(0, 1 + (pick % 2))]);
					if (i == tlen / 2 && $urandom_range(0, 4) == 0)
						push(REQ_APPEND, sym[$urandom_range(0, 1)]);
				end
			end else begin
				// noise: any request with any byte
				tlen = $urandom_range(5, 10);
				for (int i = 0; i < tlen; i++)
					push(req_t'(2'($urandom_range(0, 3))), 8'($urandom));
			end
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_requests.size() > 0 || s_tvalid || predicted_reports.size() > 0)
			@(posedge clk);
		repeat (50) @(posedge clk);

		if (n_errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
